FILE: src/stf_pkg.sv
// Shared types, character codes and case helpers for the steno translation formatter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package stf_pkg;

   // Results one item may cause: characters plus the status result.
   localparam int MAX_RESULTS = 36;
   // Leading command bytes held in flip-flops for command decoding.
   localparam int HEAD_BYTES = 10;
   // Depth of the result queue.
   localparam int RSP_DEPTH = 4;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_STAR   = 8'h2A;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_translation;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       last;
      logic       translation_done;
      logic       backspace_count;
      logic       undo;
      logic       command_only;
   } rsp_type;

   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_LBRACE,
      CLS_RBRACE,
      CLS_BSLASH,
      CLS_TEXT
   } cls_type;

   // One queued input item with its byte class.
   typedef struct packed {
      req_type req;
      cls_type cls;
   } item_type;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_CAPS   = 2'd1,
      MODE_TITLE  = 2'd2,
      MODE_LOWER  = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      CMD_NOP,
      CMD_SUPPRESS,
      CMD_ATTACH_L,
      CMD_ATTACH_R,
      CMD_CAP,
      CMD_BKSP,
      CMD_UNDO,
      CMD_PUNCT,
      CMD_FINGER,
      CMD_GLUE,
      CMD_MODE,
      CMD_UPPER,
      CMD_LOWER
   } cmd_type;

   typedef enum logic [1:0] {
      RET_TAKE,
      RET_FIN,
      RET_UNCL
   } ret_type;

   function automatic logic [7:0] to_up(input logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   function automatic logic [7:0] to_lo(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic logic [7:0] xform(input logic [7:0] c, input mode_type m,
                                        input logic first, input logic prev_sp,
                                        input logic cap, input logic upw,
                                        input logic lowr);
      logic [7:0] r;
      r = c;
      unique case (m)
         MODE_CAPS:   r = to_up(r);
         MODE_LOWER:  r = to_lo(r);
         MODE_TITLE:  if (first || prev_sp) r = to_up(r);
         MODE_NORMAL: r = c;
      endcase
      if (first && cap) r = to_up(r);
      if (upw) r = to_up(r);
      if (lowr) r = to_lo(r);
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: src/steno_translation_formatter_unit.sv
// Top level of the steno translation formatter: input queue, formatting engine,
// result queue. Depends on stf_pkg, stf_front, stf_back and stf_rsp_queue.
//
//   Channel   Ports                      Transfer when
//   input     push, full, req_data       push high and full low
//   result    empty, pop, rsp_data       pop high and empty low
//
// A plain text byte passes the take, space, character, finish and flush states, a
// byte inside braces only take, finish and flush. A closing brace that replays text
// reads each byte from the command buffer memory, then emits it. The input queue
// holds two items, so input transfers go on while the engine works or the result
// side stalls. Reset is synchronous; the command buffer memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module steno_translation_formatter_unit #(
   parameter int CMD_DEPTH    = 32,
   parameter int OUTPUT_LIMIT = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire stf_pkg::req_type req_data,
   output logic                  empty,
   input  wire logic             pop,
   output stf_pkg::rsp_type      rsp_data
);
   import stf_pkg::*;

   logic     item_valid, item_take;
   item_type item;
   logic     q_push, q_ready;
   rsp_type  q_data;

   stf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   stf_back #(
      .CMD_DEPTH    (CMD_DEPTH),
      .OUTPUT_LIMIT (OUTPUT_LIMIT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .push_o     (q_push),
      .push_data  (q_data),
      .out_ready  (q_ready)
   );

   stf_rsp_queue u_rsp (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_data  (q_data),
      .wr_ready (q_ready),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

FILE: src/stf_front.sv
// Input side: a two-entry item queue that classifies each byte on entry.
// Depends on stf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stf_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire stf_pkg::req_type req_data,
   output logic                  item_valid,
   output stf_pkg::item_type     item,
   input  wire logic             item_take
);
   import stf_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cls_type    cls;
   logic       do_push, do_pop;

   always_comb begin
      priority if (req_data.ch == 8'h00)  cls = CLS_NONE;
      else if (req_data.ch == CH_LBRACE)  cls = CLS_LBRACE;
      else if (req_data.ch == CH_RBRACE)  cls = CLS_RBRACE;
      else if (req_data.ch == CH_BSLASH)  cls = CLS_BSLASH;
      else                                cls = CLS_TEXT;
   end

   assign full       = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_take && item_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= '{req: req_data, cls: cls};
      end
   end

endmodule
`default_nettype wire

FILE: src/stf_rsp_queue.sv
// Result queue between the formatting engine and the result port.
// Depends on stf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stf_rsp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire stf_pkg::rsp_type wr_data,
   output logic                  wr_ready,
   output logic                  empty,
   input  wire logic             pop,
   output stf_pkg::rsp_type      rsp_data
);
   import stf_pkg::*;

   localparam int PW = $clog2(RSP_DEPTH);

   rsp_type       slot_ff [RSP_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_wr, do_rd;

   assign wr_ready = (count_ff != (PW+1)'(RSP_DEPTH));
   assign empty    = (count_ff == '0);
   assign rsp_data = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_en && wr_ready;
   assign do_rd    = pop && !empty;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(do_wr) - (PW+1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) slot_ff[wr_ptr_ff] <= wr_data;
   end

endmodule
`default_nettype wire

FILE: src/stf_back.sv
// Formatting engine: spacing, case and command state, the command buffer memory,
// and the sequencer that emits characters and status results. Depends on stf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stf_back #(
   parameter int CMD_DEPTH    = 32,
   parameter int OUTPUT_LIMIT = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire stf_pkg::item_type item,
   output logic                   item_take,
   output logic                   push_o,
   output stf_pkg::rsp_type       push_data,
   input  wire logic              out_ready
);
   import stf_pkg::*;

   localparam int AW = $clog2(CMD_DEPTH);
   localparam int LW = $clog2(CMD_DEPTH + 1);
   localparam int OW = $clog2(OUTPUT_LIMIT);
   localparam int IW = $clog2(MAX_RESULTS);

   typedef enum logic [15:0] {
      ST_IDLE     = 16'h0001,
      ST_TAKE     = 16'h0002,
      ST_LIT_SP   = 16'h0004,
      ST_LIT_CH   = 16'h0008,
      ST_ESC_SP   = 16'h0010,
      ST_ESC_CH   = 16'h0020,
      ST_CMD_SP   = 16'h0040,
      ST_RUN_RD   = 16'h0080,
      ST_RUN_CH   = 16'h0100,
      ST_PUNCT    = 16'h0200,
      ST_CMD_END  = 16'h0400,
      ST_FIN      = 16'h0800,
      ST_UNCL_RD  = 16'h1000,
      ST_UNCL_GET = 16'h2000,
      ST_STATUS   = 16'h4000,
      ST_FLUSH    = 16'h8000
   } state_type;

   state_type     state_ff, state_in;
   logic          sp_ff, sp_in, cap_ff, cap_in, upw_ff, upw_in, lowr_ff, lowr_in;
   logic          sup_ff, sup_in, glue_ff, glue_in;
   mode_type      mode_ff, mode_in;
   logic [LW-1:0] len_ff, len_in;
   logic          in_cmd_ff, in_cmd_in, bs_ff, bs_in, in_seg_ff, in_seg_in;
   logic [7:0]    prev_ff, prev_in;
   logic          glued_ff, glued_in, emitted_ff, emitted_in, cmd_seen_ff, cmd_seen_in;
   logic          bsf_ff, bsf_in, undof_ff, undof_in;
   logic [OW-1:0] oc_ff, oc_in;
   logic [IW-1:0] icnt_ff, icnt_in;
   logic          pend_valid_ff, pend_valid_in;

   item_type      cur_ff, cur_in;
   logic [7:0]    lit_char_ff, lit_char_in;
   logic          lit_first_ff, lit_first_in;
   ret_type       ret_ff, ret_in;
   cmd_type       kind_ff, kind_in;
   mode_type      msel_ff, msel_in;
   logic [LW-1:0] idx_ff, idx_in, run_end_ff, run_end_in;
   logic          run_first_ff, run_first_in;
   logic [7:0]    run_prev_ff, run_prev_in;
   rsp_type       pend_ff, pend_in;
   logic [7:0]    head_ff [HEAD_BYTES];
   logic [7:0]    last_byte_ff;

   logic [7:0]    cmd_mem [CMD_DEPTH];
   logic [7:0]    mem_q;
   logic          mem_we, rd_en;
   logic [AW-1:0] rd_addr;

   cmd_type       cmd_kind;
   mode_type      cmd_mode;
   logic          pfx_mode;
   logic          out_block, em_want, em_do, st_do, fl_do, can_put, glue_n;
   logic [7:0]    em_char;

   // Command decode from the held leading bytes, the length and the last byte.
   always_comb begin
      pfx_mode = (len_ff >= LW'(5)) &&
                 ({head_ff[0], head_ff[1], head_ff[2], head_ff[3], head_ff[4]} == "MODE:");
      cmd_mode = MODE_NORMAL;
      priority if (len_ff == LW'(1) && head_ff[0] == CH_CARET) cmd_kind = CMD_SUPPRESS;
      else if (len_ff > LW'(1) && head_ff[0] == CH_CARET) cmd_kind = CMD_ATTACH_L;
      else if (len_ff > LW'(1) && last_byte_ff == CH_CARET) cmd_kind = CMD_ATTACH_R;
      else if (len_ff == LW'(2) && (head_ff[0] == "-" || head_ff[0] == "~") &&
               head_ff[1] == "|") cmd_kind = CMD_CAP;
      else if ((len_ff == LW'(3) && {head_ff[0], head_ff[1], head_ff[2]} == "*-|") ||
               (len_ff == LW'(2) && {head_ff[0], head_ff[1]} == "*!")) cmd_kind = CMD_BKSP;
      else if (len_ff == LW'(2) && {head_ff[0], head_ff[1]} == "*?") cmd_kind = CMD_NOP;
      else if (len_ff == LW'(1) && head_ff[0] == CH_STAR) cmd_kind = CMD_UNDO;
      else if (len_ff == LW'(1) && (head_ff[0] == "." || head_ff[0] == "," ||
               head_ff[0] == "?" || head_ff[0] == "!" || head_ff[0] == ";" ||
               head_ff[0] == ":")) cmd_kind = CMD_PUNCT;
      else if (len_ff != '0 && head_ff[0] == CH_HASH) cmd_kind = CMD_NOP;
      else if (len_ff >= LW'(2) && head_ff[0] == CH_AMP) cmd_kind = CMD_FINGER;
      else if (len_ff == LW'(1) && head_ff[0] == CH_AMP) cmd_kind = CMD_GLUE;
      else if (pfx_mode && len_ff == LW'(9) &&
               {head_ff[5], head_ff[6], head_ff[7], head_ff[8]} == "CAPS") begin
         cmd_kind = CMD_MODE;
         cmd_mode = MODE_CAPS;
      end else if (pfx_mode && len_ff == LW'(10) &&
               {head_ff[5], head_ff[6], head_ff[7], head_ff[8], head_ff[9]} == "TITLE") begin
         cmd_kind = CMD_MODE;
         cmd_mode = MODE_TITLE;
      end else if (pfx_mode && len_ff == LW'(10) &&
               {head_ff[5], head_ff[6], head_ff[7], head_ff[8], head_ff[9]} == "LOWER") begin
         cmd_kind = CMD_MODE;
         cmd_mode = MODE_LOWER;
      end else if (pfx_mode && len_ff == LW'(10) &&
               {head_ff[5], head_ff[6], head_ff[7], head_ff[8], head_ff[9]} == "RESET") begin
         cmd_kind = CMD_MODE;
         cmd_mode = MODE_NORMAL;
      end else if (len_ff == LW'(1) && head_ff[0] == "<") cmd_kind = CMD_UPPER;
      else if (len_ff == LW'(1) && head_ff[0] == ">") cmd_kind = CMD_LOWER;
      else cmd_kind = CMD_NOP;
   end

   assign can_put = (oc_ff < OW'(OUTPUT_LIMIT - 1)) && (icnt_ff < IW'(MAX_RESULTS - 1));

   // Any state that may hand a result to the queue waits for room there.
   assign out_block = !out_ready &&
      (state_ff == ST_LIT_SP || state_ff == ST_LIT_CH || state_ff == ST_ESC_SP ||
       state_ff == ST_ESC_CH || state_ff == ST_CMD_SP || state_ff == ST_RUN_CH ||
       state_ff == ST_PUNCT  || state_ff == ST_STATUS || state_ff == ST_FLUSH);

   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      cap_in        = cap_ff;
      upw_in        = upw_ff;
      lowr_in       = lowr_ff;
      sup_in        = sup_ff;
      glue_in       = glue_ff;
      mode_in       = mode_ff;
      len_in        = len_ff;
      in_cmd_in     = in_cmd_ff;
      bs_in         = bs_ff;
      in_seg_in     = in_seg_ff;
      prev_in       = prev_ff;
      glued_in      = glued_ff;
      emitted_in    = emitted_ff;
      cmd_seen_in   = cmd_seen_ff;
      bsf_in        = bsf_ff;
      undof_in      = undof_ff;
      oc_in         = oc_ff;
      icnt_in       = icnt_ff;
      pend_valid_in = pend_valid_ff;
      cur_in        = cur_ff;
      lit_char_in   = lit_char_ff;
      lit_first_in  = lit_first_ff;
      ret_in        = ret_ff;
      kind_in       = kind_ff;
      msel_in       = msel_ff;
      idx_in        = idx_ff;
      run_end_in    = run_end_ff;
      run_first_in  = run_first_ff;
      run_prev_in   = run_prev_ff;
      pend_in       = pend_ff;
      item_take     = 1'b0;
      mem_we        = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[AW-1:0];
      em_want       = 1'b0;
      em_char       = CH_SPACE;
      em_do         = 1'b0;
      st_do         = 1'b0;
      fl_do         = 1'b0;
      glue_n        = glue_ff;
      push_o        = 1'b0;
      push_data     = pend_ff;

      if (!out_block) begin
         unique case (state_ff)
            ST_IDLE: begin
               if (item_valid) begin
                  item_take = 1'b1;
                  cur_in    = item;
                  icnt_in   = '0;
                  state_in  = ST_TAKE;
               end
            end
            ST_TAKE: begin
               state_in = ST_FIN;
               if (cur_ff.cls == CLS_NONE) begin
                  state_in = ST_FIN;
               end else if (in_cmd_ff) begin
                  if (cur_ff.cls == CLS_RBRACE) begin
                     kind_in  = cmd_kind;
                     msel_in  = cmd_mode;
                     state_in = ST_CMD_SP;
                  end else if (len_ff < LW'(CMD_DEPTH)) begin
                     mem_we = 1'b1;
                     len_in = len_ff + 1'b1;
                  end
               end else if (bs_ff) begin
                  bs_in = 1'b0;
                  if (cur_ff.cls == CLS_LBRACE || cur_ff.cls == CLS_RBRACE) begin
                     if (in_seg_ff) begin
                        upw_in    = 1'b0;
                        lowr_in   = 1'b0;
                        in_seg_in = 1'b0;
                     end
                     state_in = ST_ESC_SP;
                  end else begin
                     // The held backslash becomes text, then the byte is taken afresh.
                     lit_char_in = CH_BSLASH;
                     ret_in      = RET_TAKE;
                     state_in    = ST_LIT_SP;
                  end
               end else if (cur_ff.cls == CLS_LBRACE) begin
                  if (in_seg_ff) begin
                     upw_in    = 1'b0;
                     lowr_in   = 1'b0;
                     in_seg_in = 1'b0;
                  end
                  in_cmd_in = 1'b1;
                  len_in    = '0;
               end else if (cur_ff.cls == CLS_BSLASH) begin
                  bs_in = 1'b1;
               end else begin
                  lit_char_in = cur_ff.req.ch;
                  ret_in      = RET_FIN;
                  state_in    = ST_LIT_SP;
               end
            end
            ST_LIT_SP: begin
               lit_first_in = !in_seg_ff;
               if (!in_seg_ff) begin
                  if (!glued_ff) begin
                     em_want = sp_ff && !sup_ff;
                     sup_in  = 1'b0;
                     glue_in = 1'b0;
                  end
                  sp_in      = 1'b1;
                  in_seg_in  = 1'b1;
                  emitted_in = 1'b1;
               end
               state_in = ST_LIT_CH;
            end
            ST_LIT_CH: begin
               em_want = 1'b1;
               em_char = xform(lit_char_ff, mode_ff, lit_first_ff,
                               !lit_first_ff && prev_ff == CH_SPACE, cap_ff, upw_ff, lowr_ff);
               if (lit_first_ff) cap_in = 1'b0;
               prev_in = lit_char_ff;
               unique case (ret_ff)
                  RET_TAKE: state_in = ST_TAKE;
                  RET_UNCL: state_in = ST_UNCL_RD;
                  default:  state_in = ST_FIN;
               endcase
            end
            ST_ESC_SP: begin
               em_want  = sp_ff && !sup_ff;
               sup_in   = 1'b0;
               state_in = ST_ESC_CH;
            end
            ST_ESC_CH: begin
               em_want    = 1'b1;
               em_char    = xform(cur_ff.req.ch, mode_ff, 1'b1, 1'b0, cap_ff, upw_ff, lowr_ff);
               cap_in     = 1'b0;
               upw_in     = 1'b0;
               lowr_in    = 1'b0;
               sp_in      = 1'b1;
               glue_in    = 1'b0;
               emitted_in = 1'b1;
               state_in   = ST_FIN;
            end
            ST_CMD_SP: begin
               run_first_in = 1'b1;
               unique case (kind_ff)
                  CMD_ATTACH_L: begin
                     sup_in     = 1'b0;
                     idx_in     = LW'(1);
                     run_end_in = len_ff;
                     state_in   = ST_RUN_RD;
                  end
                  CMD_ATTACH_R: begin
                     em_want    = sp_ff && !sup_ff;
                     sup_in     = 1'b0;
                     idx_in     = '0;
                     run_end_in = len_ff - 1'b1;
                     state_in   = ST_RUN_RD;
                  end
                  CMD_FINGER: begin
                     // An active glue suppresses the space between fingerspelled strokes.
                     em_want    = sp_ff && !sup_ff && !glue_ff;
                     sup_in     = 1'b0;
                     idx_in     = LW'(1);
                     run_end_in = len_ff;
                     state_in   = ST_RUN_RD;
                  end
                  CMD_PUNCT: begin
                     sup_in   = 1'b0;
                     state_in = ST_PUNCT;
                  end
                  default: state_in = ST_CMD_END;
               endcase
            end
            ST_RUN_RD: begin
               if (idx_ff < run_end_ff) begin
                  rd_en    = 1'b1;
                  state_in = ST_RUN_CH;
               end else begin
                  state_in = ST_CMD_END;
               end
            end
            ST_RUN_CH: begin
               em_want = 1'b1;
               em_char = xform(mem_q, mode_ff, run_first_ff,
                               !run_first_ff && run_prev_ff == CH_SPACE, cap_ff, upw_ff, lowr_ff);
               if (run_first_ff) cap_in = 1'b0;
               run_first_in = 1'b0;
               run_prev_in  = mem_q;
               idx_in       = idx_ff + 1'b1;
               state_in     = ST_RUN_RD;
            end
            ST_PUNCT: begin
               em_want  = 1'b1;
               em_char  = head_ff[0];
               state_in = ST_CMD_END;
            end
            ST_CMD_END: begin
               unique case (kind_ff)
                  CMD_SUPPRESS: sup_in = 1'b1;
                  CMD_ATTACH_L: begin
                     sp_in   = 1'b1;
                     glue_n  = 1'b0;
                     upw_in  = 1'b0;
                     lowr_in = 1'b0;
                  end
                  CMD_ATTACH_R: begin
                     sup_in  = 1'b1;
                     sp_in   = 1'b0;
                     glue_n  = 1'b0;
                     upw_in  = 1'b0;
                     lowr_in = 1'b0;
                  end
                  CMD_CAP:  cap_in = 1'b1;
                  CMD_BKSP: bsf_in = 1'b1;
                  CMD_UNDO: undof_in = 1'b1;
                  CMD_PUNCT: begin
                     sp_in  = 1'b1;
                     glue_n = 1'b0;
                     if (head_ff[0] == "." || head_ff[0] == "?" || head_ff[0] == "!") begin
                        cap_in = 1'b1;
                     end
                  end
                  CMD_FINGER: begin
                     sp_in   = 1'b1;
                     glue_n  = 1'b1;
                     upw_in  = 1'b0;
                     lowr_in = 1'b0;
                  end
                  CMD_GLUE: begin
                     glue_n = 1'b1;
                     sup_in = 1'b1;
                  end
                  CMD_MODE:  mode_in = msel_ff;
                  CMD_UPPER: upw_in = 1'b1;
                  CMD_LOWER: lowr_in = 1'b1;
                  default:   glue_n = glue_ff;
               endcase
               glue_in     = glue_n;
               glued_in    = glued_ff | glue_n;
               cmd_seen_in = 1'b1;
               in_cmd_in   = 1'b0;
               len_in      = '0;
               state_in    = ST_FIN;
            end
            ST_FIN: begin
               if (!cur_ff.req.end_of_translation) begin
                  state_in = ST_FLUSH;
               end else if (bs_ff) begin
                  bs_in       = 1'b0;
                  lit_char_in = CH_BSLASH;
                  ret_in      = RET_FIN;
                  state_in    = ST_LIT_SP;
               end else begin
                  if (in_seg_ff) begin
                     upw_in    = 1'b0;
                     lowr_in   = 1'b0;
                     in_seg_in = 1'b0;
                  end
                  if (in_cmd_ff) begin
                     // An unclosed brace is written out as text, brace first.
                     in_cmd_in   = 1'b0;
                     lit_char_in = CH_LBRACE;
                     ret_in      = RET_UNCL;
                     idx_in      = '0;
                     state_in    = ST_LIT_SP;
                  end else begin
                     state_in = ST_STATUS;
                  end
               end
            end
            ST_UNCL_RD: begin
               if (idx_ff < len_ff) begin
                  rd_en    = 1'b1;
                  state_in = ST_UNCL_GET;
               end else begin
                  state_in = ST_FIN;
               end
            end
            ST_UNCL_GET: begin
               lit_char_in = mem_q;
               idx_in      = idx_ff + 1'b1;
               ret_in      = RET_UNCL;
               state_in    = ST_LIT_SP;
            end
            ST_STATUS: begin
               st_do       = 1'b1;
               len_in      = '0;
               in_cmd_in   = 1'b0;
               bs_in       = 1'b0;
               in_seg_in   = 1'b0;
               prev_in     = 8'h00;
               glued_in    = 1'b0;
               emitted_in  = 1'b0;
               cmd_seen_in = 1'b0;
               bsf_in      = 1'b0;
               undof_in    = 1'b0;
               oc_in       = '0;
               state_in    = ST_FLUSH;
            end
            ST_FLUSH: begin
               fl_do         = pend_valid_ff;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
            default: state_in = ST_IDLE;
         endcase

         // One result is held back so that the final one of an item can carry last.
         em_do = em_want && can_put;
         if (em_do) begin
            oc_in   = oc_ff + 1'b1;
            icnt_in = icnt_ff + 1'b1;
         end
         if (em_do || st_do) begin
            push_o         = pend_valid_ff;
            push_data      = pend_ff;
            push_data.last = 1'b0;
            pend_valid_in  = 1'b1;
            if (st_do) begin
               pend_in = '{out_char: 8'h00, char_valid: 1'b0, last: 1'b0,
                           translation_done: 1'b1, backspace_count: bsf_ff, undo: undof_ff,
                           command_only: !emitted_ff && (!cmd_seen_ff || oc_ff == '0)};
            end else begin
               pend_in = '{out_char: em_char, char_valid: 1'b1, last: 1'b0,
                           translation_done: 1'b0, backspace_count: 1'b0, undo: 1'b0,
                           command_only: 1'b0};
            end
         end
         if (fl_do) begin
            push_o         = 1'b1;
            push_data      = pend_ff;
            push_data.last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sp_ff         <= 1'b0;
         cap_ff        <= 1'b0;
         upw_ff        <= 1'b0;
         lowr_ff       <= 1'b0;
         sup_ff        <= 1'b0;
         glue_ff       <= 1'b0;
         mode_ff       <= MODE_NORMAL;
         len_ff        <= '0;
         in_cmd_ff     <= 1'b0;
         bs_ff         <= 1'b0;
         in_seg_ff     <= 1'b0;
         prev_ff       <= 8'h00;
         glued_ff      <= 1'b0;
         emitted_ff    <= 1'b0;
         cmd_seen_ff   <= 1'b0;
         bsf_ff        <= 1'b0;
         undof_ff      <= 1'b0;
         oc_ff         <= '0;
         icnt_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sp_ff         <= sp_in;
         cap_ff        <= cap_in;
         upw_ff        <= upw_in;
         lowr_ff       <= lowr_in;
         sup_ff        <= sup_in;
         glue_ff       <= glue_in;
         mode_ff       <= mode_in;
         len_ff        <= len_in;
         in_cmd_ff     <= in_cmd_in;
         bs_ff         <= bs_in;
         in_seg_ff     <= in_seg_in;
         prev_ff       <= prev_in;
         glued_ff      <= glued_in;
         emitted_ff    <= emitted_in;
         cmd_seen_ff   <= cmd_seen_in;
         bsf_ff        <= bsf_in;
         undof_ff      <= undof_in;
         oc_ff         <= oc_in;
         icnt_ff       <= icnt_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      lit_char_ff  <= lit_char_in;
      lit_first_ff <= lit_first_in;
      ret_ff       <= ret_in;
      kind_ff      <= kind_in;
      msel_ff      <= msel_in;
      idx_ff       <= idx_in;
      run_end_ff   <= run_end_in;
      run_first_ff <= run_first_in;
      run_prev_ff  <= run_prev_in;
      pend_ff      <= pend_in;
      if (mem_we) begin
         last_byte_ff <= cur_ff.req.ch;
         for (int i = 0; i < HEAD_BYTES; i++) begin
            if (len_ff == LW'(i)) head_ff[i] <= cur_ff.req.ch;
         end
      end
   end

   // Command buffer memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) cmd_mem[len_ff[AW-1:0]] <= cur_ff.req.ch;
      if (rd_en) mem_q <= cmd_mem[rd_addr];
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(CMD_DEPTH))
      else $error("command length beyond buffer depth");

   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      oc_ff <= OW'(OUTPUT_LIMIT - 1))
      else $error("translation output count beyond limit");

   a_status_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STATUS && out_ready) |=>
      (state_ff == ST_FLUSH && pend_valid_ff && pend_ff.translation_done))
      else $error("status result not held for the final transfer");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_o |-> out_ready)
      else $error("result pushed into a full queue");

endmodule
`default_nettype wire
